// ===== sv/gaic_pkg.sv =====
// Shared types and constants for the gyro angle integrator with bias calibration.
// No dependencies; imported by gaic_div, gaic_lane and the top level.
package gaic_pkg;

  localparam int AXIS_COUNT_DEF = 3;
  localparam int MAX_CAL_DEF    = 65536;

  localparam int RAW_W     = 16;
  localparam int RATE_W    = 25;
  localparam int BIAS_W    = 24;
  localparam int ANG_W     = 48;
  localparam int DIVD_W    = 84;
  localparam int DIVS_W    = 48;
  localparam int Q_W       = 50;
  localparam int DIV_STEPS = 84;
  localparam int ITER_W    = 7;

  localparam logic [25:0]    ANGLE_K   = 26'd65536000;
  localparam logic [ANG_W:0] INC_LIMIT = {1'b1, {ANG_W{1'b0}}};

  localparam logic CFG_CAL_COUNT = 1'b0;
  localparam logic CFG_TICK_RATE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_ADIV,
    ST_ARND,
    ST_BLOAD,
    ST_BDIV,
    ST_BSET,
    ST_OUT
  } gaic_state_t;

  typedef struct packed {
    gaic_state_t st;
    logic        first;
    logic        collect;
    logic        clr;
  } gaic_ctl_t;

endpackage

// ===== sv/gaic_div.sv =====
// Restoring divider, one quotient bit per step, with a saturation flag for quotients above 2^48.
// Depends on gaic_pkg.
module gaic_div import gaic_pkg::*; (
  input  logic              clk,
  input  logic              load,
  input  logic              step,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic [Q_W-1:0]    quo,
  output logic [DIVS_W-1:0] rem,
  output logic              sat
);

  logic [DIVD_W-1:0] dvd_r;
  logic [DIVS_W-1:0] dvs_r;
  logic [DIVS_W-1:0] rem_r;
  logic [Q_W-1:0]    q_r;
  logic              sat_r;

  logic [DIVS_W:0]   rem_sh;
  logic              ge;
  logic [DIVS_W:0]   rem_sub;
  logic [Q_W-1:0]    q_nxt;
  logic              over;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[DIVD_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_sub = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
    q_nxt   = {q_r[Q_W-2:0], ge};
    over    = q_nxt > {{(Q_W-ANG_W-1){1'b0}}, INC_LIMIT};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      sat_r <= 1'b0;
    end else if (step) begin
      dvd_r <= {dvd_r[DIVD_W-2:0], 1'b0};
      rem_r <= rem_sub[DIVS_W-1:0];
      q_r   <= q_nxt;
      sat_r <= sat_r | over;
    end
  end

  assign quo = q_r;
  assign rem = rem_r;
  assign sat = sat_r;

endmodule

// ===== sv/gaic_lane.sv =====
// One axis lane: bias removal, trapezoid increment, angle accumulate, bias average.
// Depends on gaic_pkg and gaic_div.
module gaic_lane import gaic_pkg::*; #(
  parameter int CNT_W = 17
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gaic_ctl_t               ctl,
  input  logic signed [RAW_W-1:0] raw,
  input  logic [31:0]             dt,
  input  logic [DIVS_W-1:0]       div,
  input  logic [CNT_W-1:0]        cnt,
  output logic signed [ANG_W-1:0] angle
);

  localparam int SUM_W  = RAW_W + CNT_W;
  localparam int BNUM_W = SUM_W + 10;

  logic signed [RATE_W-1:0] prev_r;
  logic signed [ANG_W-1:0]  angle_r;
  logic signed [BIAS_W-1:0] bias_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [RATE_W:0]   s_r;
  logic [57:0]              a_r;
  logic [57:0]              p0_r;
  logic [51:0]              p1_r;

  logic signed [RATE_W-1:0] rate;
  logic [RATE_W:0]          mag;
  logic                     div_load;
  logic                     div_step;
  logic [DIVD_W-1:0]        dividend;
  logic [DIVS_W-1:0]        divisor;
  logic [Q_W-1:0]           quo;
  logic [DIVS_W-1:0]        rem;
  logic                     sat;
  logic                     rb;
  logic [Q_W-1:0]           inc_full;
  logic [ANG_W:0]           inc;
  logic signed [ANG_W+2:0]  tot;
  logic signed [ANG_W-1:0]  angle_nxt;
  logic [SUM_W-1:0]         m;
  logic [BNUM_W-1:0]        bnum;
  logic signed [BIAS_W-1:0] bias_nxt;

  always_comb begin
    rate = {{(RATE_W-RAW_W-8){raw[RAW_W-1]}}, raw, 8'd0}
         - {{(RATE_W-BIAS_W){bias_r[BIAS_W-1]}}, bias_r};
    mag  = s_r[RATE_W] ? 26'(-s_r) : 26'(s_r);
    m    = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    bnum = {1'b0, m, 9'd0} + BNUM_W'(cnt);
    div_load = (ctl.st == ST_MUL3) || (ctl.st == ST_BLOAD);
    div_step = (ctl.st == ST_ADIV) || (ctl.st == ST_BDIV);
    if (ctl.st == ST_BLOAD) begin
      dividend = DIVD_W'(bnum);
      divisor  = DIVS_W'({cnt, 1'b0});
    end else begin
      dividend = {p1_r, 32'd0} + DIVD_W'(p0_r);
      divisor  = div;
    end
    rb       = {rem, 1'b0} >= {1'b0, div};
    inc_full = quo + Q_W'(rb);
    if (sat || inc_full > Q_W'(INC_LIMIT)) inc = INC_LIMIT;
    else inc = inc_full[ANG_W:0];
    tot = {{3{angle_r[ANG_W-1]}}, angle_r}
        + (s_r[RATE_W] ? -$signed({2'b0, inc}) : $signed({2'b0, inc}));
    if (tot > $signed({3'b000, {(ANG_W-1){1'b1}}})) angle_nxt = {1'b0, {(ANG_W-1){1'b1}}};
    else if (tot < $signed({3'b111, {(ANG_W-1){1'b0}}})) angle_nxt = {1'b1, {(ANG_W-1){1'b0}}};
    else angle_nxt = tot[ANG_W-1:0];
    bias_nxt = sum_r[SUM_W-1] ? -$signed(quo[BIAS_W-1:0]) : $signed(quo[BIAS_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      angle_r <= '0;
      bias_r  <= '0;
      sum_r   <= '0;
    end else begin
      if (ctl.clr) sum_r <= '0;
      case (ctl.st)
        ST_LOAD: begin
          prev_r <= rate;
          if (ctl.collect && !ctl.first) sum_r <= sum_r + SUM_W'(raw);
        end
        ST_ARND: angle_r <= angle_nxt;
        ST_BSET: begin
          bias_r  <= bias_nxt;
          angle_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.st == ST_LOAD) s_r <= (RATE_W+1)'(prev_r) + (RATE_W+1)'(rate);
    if (ctl.st == ST_MUL0) a_r <= 58'(mag) * 58'(dt);
    if (ctl.st == ST_MUL1) p0_r <= 58'(a_r[31:0]) * 58'(ANGLE_K);
    if (ctl.st == ST_MUL2) p1_r <= a_r[57:32] * ANGLE_K;
  end

  gaic_div u_div (
    .clk      (clk),
    .load     (div_load),
    .step     (div_step),
    .dividend (dividend),
    .divisor  (divisor),
    .quo      (quo),
    .rem      (rem),
    .sat      (sat)
  );

  assign angle = angle_r;

endmodule

// ===== sv/gyro_angle_integrator_with_bias_cal_unit.sv =====
// Top level: sequencer, calibration control, axis lanes and output word register.
// Depends on gaic_pkg, gaic_lane (and through it gaic_div).
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata raw_x,raw_y,raw_z,timestamp; tuser kind
//  out_    | out | out_tvalid/tready  | tdata angle_x,angle_y,angle_z; tuser calibrating,done
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// A start word goes straight to the output state; a sample word runs load, the multiply states
// and the angle division, plus the bias division on the word that ends calibration; the first
// sample after reset skips the angle work. Each lane's 84-step restoring divider is shared by
// the angle increment and the bias average. Reset is synchronous and needs no clearing pass.
// A stalled output holds the finished word; the next input word is taken meanwhile.
module gyro_angle_integrator_with_bias_cal_unit import gaic_pkg::*; #(
  parameter int AXIS_COUNT      = AXIS_COUNT_DEF,
  parameter int MAX_CAL_SAMPLES = MAX_CAL_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // raw_x, raw_y, raw_z, timestamp
  input  logic         in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // angle_x, angle_y, angle_z
  output logic [1:0]   out_tuser,  // calibrating, calibration_done
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int CNT_W = $clog2(MAX_CAL_SAMPLES + 1);
  localparam int TW    = (CNT_W > 17 ? CNT_W : 17) + 1;

  gaic_state_t state_r, state_nxt;

  logic [16:0]       cal_count_r;
  logic [31:0]       tick_rate_r;
  logic              first_pend_r;
  logic [31:0]       prev_ts_r;
  logic [CNT_W-1:0]  counted_r;
  logic              active_r;
  logic              first_r;
  logic              collect_r;
  logic              done_r;
  logic [31:0]       dt_r;
  logic [DIVS_W-1:0] div_r;
  logic [ITER_W-1:0] iter_r;
  logic signed [RAW_W-1:0] raw_r [3];
  logic              out_valid_r;
  logic [143:0]      out_data_r;
  logic [1:0]        out_user_r;

  logic              accept;
  logic [TW-1:0]     cc;
  logic [TW-1:0]     target;
  logic              collect;
  logic [CNT_W-1:0]  counted_new;
  logic              done;
  logic [31:0]       tick;
  logic              div_last;
  logic              out_load;
  gaic_ctl_t         ctl;
  logic signed [ANG_W-1:0] angles [3];

  assign accept    = (state_r == ST_IDLE) && in_tvalid;
  assign cfg_ready = 1'b1;
  assign div_last  = iter_r == ITER_W'(DIV_STEPS - 1);

  always_comb begin
    cc          = TW'(cal_count_r);
    if (cc == '0) target = TW'(1);
    else if (cc > TW'(MAX_CAL_SAMPLES)) target = TW'(MAX_CAL_SAMPLES);
    else target = cc;
    collect     = active_r && (TW'(counted_r) < target);
    counted_new = counted_r + CNT_W'(collect);
    done        = active_r && (TW'(counted_new) >= target);
    tick        = (tick_rate_r == 32'd0) ? 32'd1 : tick_rate_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = in_tuser ? ST_OUT : ST_LOAD;
      ST_LOAD:  state_nxt = first_r ? (done_r ? ST_BLOAD : ST_OUT) : ST_MUL0;
      ST_MUL0:  state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_MUL3;
      ST_MUL3:  state_nxt = ST_ADIV;
      ST_ADIV:  if (div_last) state_nxt = ST_ARND;
      ST_ARND:  state_nxt = done_r ? ST_BLOAD : ST_OUT;
      ST_BLOAD: state_nxt = ST_BDIV;
      ST_BDIV:  if (div_last) state_nxt = ST_BSET;
      ST_BSET:  state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = state_r == ST_IDLE;
    out_load    = (state_r == ST_OUT) && (!out_valid_r || out_tready);
    ctl.st      = state_r;
    ctl.first   = first_r;
    ctl.collect = collect_r;
    ctl.clr     = accept && in_tuser;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cal_count_r  <= 17'd1000;
      tick_rate_r  <= 32'd168000000;
      first_pend_r <= 1'b1;
      prev_ts_r    <= '0;
      counted_r    <= '0;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      iter_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_CAL_COUNT: cal_count_r <= cfg_data[16:0];
          CFG_TICK_RATE: tick_rate_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (in_tuser) begin
          counted_r <= '0;
          active_r  <= 1'b1;
        end else begin
          prev_ts_r    <= in_tdata[79:48];
          first_pend_r <= 1'b0;
          counted_r    <= counted_new;
          if (done) active_r <= 1'b0;
        end
      end
      if (state_r == ST_MUL3 || state_r == ST_BLOAD) iter_r <= '0;
      else if (state_r == ST_ADIV || state_r == ST_BDIV) iter_r <= iter_r + ITER_W'(1);
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_r[0]  <= in_tdata[15:0];
      raw_r[1]  <= in_tdata[31:16];
      raw_r[2]  <= in_tdata[47:32];
      dt_r      <= in_tdata[79:48] - prev_ts_r;
      div_r     <= {1'b0, tick, 15'd0} - DIVS_W'(tick);
      first_r   <= first_pend_r;
      collect_r <= collect && !in_tuser;
      done_r    <= done && !in_tuser;
    end
    if (out_load) begin
      out_data_r <= {angles[2], angles[1], angles[0]};
      out_user_r <= {done_r, active_r};
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_lane
    if (a < AXIS_COUNT) begin : g_on
      gaic_lane #(.CNT_W(CNT_W)) u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .raw   (raw_r[a]),
        .dt    (dt_r),
        .div   (div_r),
        .cnt   (counted_r),
        .angle (angles[a])
      );
    end else begin : g_off
      assign angles[a] = '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_done_ends_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[1] && out_tuser[0]))
    else $error("calibration done reported while still calibrating");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    TW'(counted_r) <= TW'(MAX_CAL_SAMPLES))
    else $error("sample count beyond limit");

  a_start_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser) |=> (active_r && counted_r == '0))
    else $error("start word did not open calibration");

  a_div_iter: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADIV || state_r == ST_BDIV) |-> iter_r < ITER_W'(DIV_STEPS))
    else $error("divider ran past its step count");

endmodule

// ===== test/gyro_angle_integrator_with_bias_cal_unit_test.sv =====
// Testbench for gyro_angle_integrator_with_bias_cal_unit: directed and random sample,
// start and register traffic, each output word checked against a built-in predictor.
// Depends on gaic_pkg and the top level only.
module gyro_angle_integrator_with_bias_cal_unit_test;
  import gaic_pkg::*;

  localparam logic KIND_SAMPLE   = 1'b0;
  localparam logic KIND_START    = 1'b1;
  localparam longint ANGLE_HI    = 64'sd140737488355327;
  localparam longint ANGLE_LO    = -64'sd140737488355328;
  localparam logic [127:0] INC_CAP = 128'd1 << 48;

  typedef struct packed {
    logic [143:0] angles;
    logic [1:0]   flags;
  } angle_word_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [79:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = 1'b0;
  logic [31:0]  cfg_data = '0;

  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  int unsigned errors = 0;
  angle_word_t angle_q[$];

  // predictor state
  logic [16:0]  cal_target_reg = 17'd1000;
  logic [31:0]  tick_rate_reg = 32'd168000000;
  bit           first_pend = 1'b1;
  logic [31:0]  last_ts = '0;
  int           prior_rate[3] = '{0, 0, 0};
  longint       angle_acc[3] = '{0, 0, 0};
  int           axis_bias[3] = '{0, 0, 0};
  longint       raw_sum[3] = '{0, 0, 0};
  int unsigned  cal_seen = 0;
  bit           cal_on = 1'b0;
  logic [31:0]  ts_now = '0;

  gyro_angle_integrator_with_bias_cal_unit u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #400000000;
    $display("Some tests failed");
    $finish;
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= out_idle_pct);

  task automatic report(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic longint unsigned rate_increment(longint unsigned mag, logic [31:0] dt,
                                                     logic [127:0] dv);
    logic [127:0] prod;
    logic [127:0] q;
    logic [127:0] r;
    prod = 128'(mag) * 128'(dt) * 128'(ANGLE_K);
    q = prod / dv;
    r = prod % dv;
    if (q > INC_CAP) return INC_CAP[63:0];
    if (r * 2 >= dv) q++;
    if (q > INC_CAP) q = INC_CAP;
    return q[63:0];
  endfunction

  task automatic predict_word(logic kind, logic signed [15:0] raw[3], logic [31:0] ts);
    angle_word_t w;
    bit done;
    bit collect;
    longint unsigned target;
    logic [127:0] dv;
    logic [31:0] dt;
    int rate;
    longint s;
    longint inc;
    longint unsigned m;
    longint unsigned q;
    done = 1'b0;
    if (kind == KIND_START) begin
      raw_sum = '{0, 0, 0};
      cal_seen = 0;
      cal_on = 1'b1;
    end else begin
      dt = ts - last_ts;
      target = cal_target_reg;
      if (target < 1) target = 1;
      if (target > 65536) target = 65536;
      dv = 128'(tick_rate_reg == 0 ? 32'd1 : tick_rate_reg) * 128'd32767;
      collect = cal_on && (cal_seen < target);
      for (int i = 0; i < 3; i++) begin
        rate = int'(raw[i]) * 256 - axis_bias[i];
        if (!first_pend) begin
          s = longint'(prior_rate[i]) + longint'(rate);
          inc = longint'(rate_increment(s < 0 ? -s : s, dt, dv));
          if (collect) raw_sum[i] += raw[i];
          s = angle_acc[i] + (s < 0 ? -inc : inc);
          angle_acc[i] = s > ANGLE_HI ? ANGLE_HI : (s < ANGLE_LO ? ANGLE_LO : s);
        end
        prior_rate[i] = rate;
      end
      first_pend = 1'b0;
      last_ts = ts;
      if (collect) cal_seen++;
      if (cal_on && cal_seen >= target) begin
        for (int i = 0; i < 3; i++) begin
          m = raw_sum[i] < 0 ? -raw_sum[i] : raw_sum[i];
          q = (m * 512 + cal_seen) / (2 * cal_seen);
          axis_bias[i] = raw_sum[i] < 0 ? -int'(q) : int'(q);
          angle_acc[i] = 0;
        end
        cal_on = 1'b0;
        done = 1'b1;
      end
    end
    w.angles = {angle_acc[2][47:0], angle_acc[1][47:0], angle_acc[0][47:0]};
    w.flags = {done, cal_on};
    angle_q.push_back(w);
  endtask

  always @(posedge clk) begin
    angle_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (angle_q.size() == 0) begin
        report("unexpected word", out_tdata[47:0], '0);
      end else begin
        w = angle_q.pop_front();
        for (int i = 0; i < 3; i++)
          if (out_tdata[48*i +: 48] !== w.angles[48*i +: 48])
            report($sformatf("angle %0d", i), out_tdata[48*i +: 48], w.angles[48*i +: 48]);
        if (out_tuser[0] !== w.flags[0]) report("calibrating", out_tuser[0], w.flags[0]);
        if (out_tuser[1] !== w.flags[1]) report("calibration_done", out_tuser[1], w.flags[1]);
      end
    end
  end

  task automatic send_word(logic kind, logic signed [15:0] rx, logic signed [15:0] ry,
                           logic signed [15:0] rz, logic [31:0] ts);
    logic signed [15:0] raw[3];
    raw = '{rx, ry, rz};
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {ts, rz, ry, rx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_word(kind, raw, ts);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic sample(int rx, int ry, int rz, logic [31:0] step);
    ts_now += step;
    send_word(KIND_SAMPLE, 16'(rx), 16'(ry), 16'(rz), ts_now);
  endtask

  task automatic start_cal();
    send_word(KIND_START, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic drain();
    while (angle_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_CAL_COUNT) cal_target_reg = val[16:0];
    else tick_rate_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_first_and_extremes();
    ts_now = 32'd100;
    send_word(KIND_SAMPLE, 16'sh7fff, -16'sh8000, 16'sd0, ts_now);
    sample(-32768, 32767, -1, 32'd200000);
    sample(32767, 32767, 32767, 32'd1);
    sample(-32768, -32768, -32768, 32'd0);
    ts_now = 32'hfffffff0;
    sample(1000, -1000, 5, 32'd0);
    sample(1000, -1000, 5, 32'h20);
    drain();
  endtask

  task automatic test_calibration();
    write_reg(CFG_CAL_COUNT, 32'd3);
    drain();
    start_cal();
    sample(10, -11, 1, 32'd4000);
    sample(11, -12, 0, 32'd4000);
    sample(11, -12, 1, 32'd4000);
    sample(300, 300, 300, 32'd4000);
    drain();
    write_reg(CFG_CAL_COUNT, 32'd0);
    drain();
    start_cal();
    sample(-7, 7, 3, 32'd1000);
    drain();
    write_reg(CFG_CAL_COUNT, 32'h1ffff);
    drain();
    start_cal();
    sample(1, 2, 3, 32'd1000);
    sample(4, 5, 6, 32'd1000);
    sample(7, 8, 9, 32'd1000);
    drain();
    write_reg(CFG_CAL_COUNT, 32'd2);
    drain();
    sample(0, 0, 0, 32'd1000);
    drain();
  endtask

  task automatic test_tick_rates();
    write_reg(CFG_TICK_RATE, 32'd1);
    drain();
    sample(32767, -32768, 100, 32'hffffffff);
    sample(32767, -32768, 100, 32'hffffffff);
    sample(32767, -32768, -100, 32'h80000000);
    drain();
    write_reg(CFG_TICK_RATE, 32'd0);
    drain();
    sample(-32768, 32767, 0, 32'd3);
    drain();
    write_reg(CFG_TICK_RATE, 32'hffffffff);
    drain();
    sample(12345, -23456, 32767, 32'hffffffff);
    sample(-1, 1, 0, 32'd77);
    drain();
  endtask

  task automatic test_random(int n);
    int kindr;
    for (int k = 0; k < n; k++) begin
      if (k % 110 == 0) begin
        drain();
        write_reg(CFG_CAL_COUNT, $urandom_range(1, 12));
        write_reg(CFG_TICK_RATE, $urandom_range(3) == 0 ? $urandom :
                  $urandom_range(1000, 200000000));
        drain();
      end
      kindr = $urandom_range(99);
      if (kindr < 4) begin
        start_cal();
      end else if (kindr < 15) begin
        ts_now = $urandom;
        send_word(KIND_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom), ts_now);
      end else begin
        sample($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
               $urandom_range(0, 4000) - 2000,
               $urandom_range(7) == 0 ? $urandom : $urandom_range(1, 400000));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_reg(CFG_TICK_RATE, 32'd168000000);
    test_first_and_extremes();
    test_calibration();
    test_tick_rates();
    write_reg(CFG_TICK_RATE, 32'd1000000);
    drain();
    in_idle_pct = 35;
    out_idle_pct = 81;
    test_random(330);
    in_idle_pct = 81;
    out_idle_pct = 35;
    test_random(330);
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random(340);
    while (angle_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
